// ===== src/flm_pkg.sv =====
// ----------------------------------------------------------------------------
// flm_pkg: shared types for the max-tracking queue
// Command and status codes, the data word and the per-step control beat.
// ----------------------------------------------------------------------------
package flm_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_POP_EMPTY  = 2'd1,
        STATUS_PUSH_FULL  = 2'd2
    } status_t;

    // control info of one accepted beat, leaving the queue stage
    typedef struct packed {
        logic    strobe;   // a beat was accepted at the last edge
        logic    bypass;   // new head was written this beat, RAM data is stale
        status_t status;
    } step_t;

endpackage

// ===== src/fifo_with_running_maximum.sv =====
// ----------------------------------------------------------------------------
// fifo_with_running_maximum: queue of signed words with live maximum
// Push/pop queue that reports front, back, true maximum, count and status
// after every beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a beat is taken on a rising edge with start high and busy
//   low. command selects push (value goes to the back) or pop (front leaves).
//   busy never rises, so one beat can be issued on every clock.
//   Result channel: done pulses for one cycle with front_value, back_value,
//   max_value, count, is_empty and status for that beat. The receiver cannot
//   stall; results come out in issue order, one per accepted beat.
//   Each beat passes the queue stage, which updates the pointers, and then
//   the registered levels of the compare tree that finds the maximum.
//   Throughput: one beat per cycle.
//   A pop on an empty queue or a push on a full one reports its status code
//   and leaves the queue alone. Value outputs read zero when empty.
//   Reset (rst_n low, asynchronous) empties the queue and drops any beats
//   still in flight; entry storage is not cleared.
// ----------------------------------------------------------------------------
module fifo_with_running_maximum
    import flm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       command,
    input  logic signed [31:0]         value,
    output logic                       done,
    output logic signed [31:0]         front_value,
    output logic signed [31:0]         back_value,
    output logic signed [31:0]         max_value,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       is_empty,
    output logic [1:0]                 status
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LEVELS = $clog2(DEPTH);

    // side info waiting for the tree to settle
    typedef struct packed {
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] back;
        logic [CNT_W-1:0]  count;
        status_t           status;
    } side_t;

    logic              accept;
    word_t             q_leaf_value [DEPTH];
    logic [DEPTH-1:0]  q_leaf_valid;
    step_t             q_step;
    logic [CNT_W-1:0]  q_count;
    word_t             q_front;
    word_t             q_back;
    logic              root_valid;
    word_t             root_value;

    logic [LEVELS-1:0] strobe_reg, strobe_next;
    side_t             side_reg [LEVELS];
    side_t             side_next [LEVELS];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    flm_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (command),
        .value      (value),
        .leaf_value (q_leaf_value),
        .leaf_valid (q_leaf_valid),
        .step       (q_step),
        .count      (q_count),
        .front      (q_front),
        .back       (q_back)
    );

    flm_max_tree #(
        .DEPTH (DEPTH)
    ) u_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_value (q_leaf_value),
        .leaf_valid (q_leaf_valid),
        .root_valid (root_valid),
        .root_value (root_value)
    );

    // delay line matched to the tree depth; empty queue zeroes the values
    always_comb
    begin
        strobe_next[0]      = q_step.strobe;
        side_next[0].front  = (q_count == '0) ? '0 : q_front;
        side_next[0].back   = (q_count == '0) ? '0 : q_back;
        side_next[0].count  = q_count;
        side_next[0].status = q_step.status;
        for (int k = 1; k < LEVELS; k++)
        begin
            strobe_next[k] = strobe_reg[k-1];
            side_next[k]   = side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
    end

    assign done        = strobe_reg[LEVELS-1];
    assign front_value = side_reg[LEVELS-1].front;
    assign back_value  = side_reg[LEVELS-1].back;
    assign max_value   = root_valid ? root_value : '0;
    assign count       = side_reg[LEVELS-1].count;
    assign is_empty    = (side_reg[LEVELS-1].count == '0);
    assign status      = side_reg[LEVELS-1].status;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LEVELS + 1) done)
        else $error("accepted beat produced no result");

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(rst_n, LEVELS + 1) |-> $past(accept, LEVELS + 1))
        else $error("result without an accepted beat");

    a_max_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_empty |-> (max_value >= front_value) && (max_value >= back_value))
        else $error("maximum below front or back entry");

endmodule

// ===== src/flm_ram.sv =====
// ----------------------------------------------------------------------------
// flm_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module flm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/flm_queue.sv =====
// ----------------------------------------------------------------------------
// flm_queue: circular queue state
// Head/count pointers, occupancy bits, tree leaves and a RAM mirror whose
// registered read port supplies the front entry after each beat.
// ----------------------------------------------------------------------------
module flm_queue
    import flm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       command,
    input  word_t                      value,
    output word_t                      leaf_value [DEPTH],
    output logic [DEPTH-1:0]           leaf_valid,
    output step_t                      step,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output word_t                      front,
    output word_t                      back
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    step_t            step_reg, step_next;
    word_t            leaf_reg [DEPTH];
    word_t            back_reg;
    word_t            hold_reg;

    logic             is_full;
    logic             is_zero;
    logic [SUM_W-1:0] tail_sum;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_inc;
    logic             do_push;
    logic             do_pop;
    logic [WORD_W-1:0] ram_rdata;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_zero  = (count_reg == '0);
    // count < DEPTH whenever the tail is used, so it fits PTR_W bits
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg[PTR_W-1:0]);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : tail_sum[PTR_W-1:0];
    assign head_inc = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign do_push  = accept && (command == CMD_PUSH) && !is_full;
    assign do_pop   = accept && (command == CMD_POP) && !is_zero;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        step_next.strobe = accept;
        step_next.bypass = do_push && is_zero;
        step_next.status = STATUS_OK;
        if (do_push)
        begin
            count_next       = count_reg + 1'b1;
            valid_next[tail] = 1'b1;
        end
        if (do_pop)
        begin
            head_next            = head_inc;
            count_next           = count_reg - 1'b1;
            valid_next[head_reg] = 1'b0;
        end
        if (accept && (command == CMD_PUSH) && is_full)
        begin
            step_next.status = STATUS_PUSH_FULL;
        end
        if (accept && (command == CMD_POP) && is_zero)
        begin
            step_next.status = STATUS_POP_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            valid_reg <= '0;
            step_reg  <= '{strobe: 1'b0, bypass: 1'b0, status: STATUS_OK};
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            leaf_reg[tail] <= value;
            back_reg       <= value;
        end
        if (accept)
        begin
            hold_reg <= value;
        end
    end

    // mirror of the entries; read address tracks the head after this beat
    flm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (tail),
        .wdata (value),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign leaf_value = leaf_reg;
    assign leaf_valid = valid_reg;
    assign step       = step_reg;
    assign count      = count_reg;
    assign back       = back_reg;
    // push into an empty queue writes the head in the same cycle it is read
    assign front      = step_reg.bypass ? hold_reg : word_t'(ram_rdata);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("occupancy bits disagree with count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg.strobe && (step_reg.status == STATUS_PUSH_FULL)
        |-> count_reg == CNT_W'(DEPTH))
        else $error("push rejected while not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg.strobe && (step_reg.status == STATUS_POP_EMPTY) |-> count_reg == '0)
        else $error("pop rejected while not empty");

endmodule

// ===== src/flm_max_tree.sv =====
// ----------------------------------------------------------------------------
// flm_max_tree: pipelined maximum over the occupied entries
// Binary heap of registered compare nodes, one tree level per clock.
// ----------------------------------------------------------------------------
module flm_max_tree
    import flm_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  word_t            leaf_value [DEPTH],
    input  logic [DEPTH-1:0] leaf_valid,
    output logic             root_valid,
    output word_t            root_value
);

    localparam int LEVELS = $clog2(DEPTH);
    localparam int NLEAF  = 1 << LEVELS;
    localparam int NINT   = NLEAF - 1;
    localparam int NODES  = 2 * NLEAF - 1;

    word_t            node_val_reg [NINT];
    logic [NINT-1:0]  node_vld_reg;
    word_t            node_val_next [NINT];
    logic [NINT-1:0]  node_vld_next;
    word_t            all_val [NODES];
    logic [NODES-1:0] all_vld;

    // heap view: internal registers first, then padded leaves
    always_comb
    begin
        for (int i = 0; i < NINT; i++)
        begin
            all_val[i] = node_val_reg[i];
            all_vld[i] = node_vld_reg[i];
        end
        for (int i = 0; i < NLEAF; i++)
        begin
            if (i < DEPTH)
            begin
                all_val[NINT + i] = leaf_value[i];
                all_vld[NINT + i] = leaf_valid[i];
            end
            else
            begin
                all_val[NINT + i] = '0;
                all_vld[NINT + i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int n = 0; n < NINT; n++)
        begin
            if (all_vld[2*n+1] && (!all_vld[2*n+2] || all_val[2*n+1] >= all_val[2*n+2]))
            begin
                node_val_next[n] = all_val[2*n+1];
            end
            else
            begin
                node_val_next[n] = all_val[2*n+2];
            end
            node_vld_next[n] = all_vld[2*n+1] || all_vld[2*n+2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_vld_reg <= '0;
        end
        else
        begin
            node_vld_reg <= node_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_val_reg <= node_val_next;
    end

    assign root_valid = node_vld_reg[0];
    assign root_value = node_val_reg[0];

endmodule

// ===== verif/fifo_with_running_maximum_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_with_running_maximum_tb: self-checking bench for the max-tracking queue
// Sends push/pop beats through the start/busy port, keeps its own queue to
// predict every result beat, and checks front, back, maximum, count, empty
// flag and status of each done pulse in issue order.
// ----------------------------------------------------------------------------
module fifo_with_running_maximum_tb
    import flm_pkg::*;
();

    localparam int DEPTH           = 16;
    localparam int LATENCY         = $clog2(DEPTH) + 1;
    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    // allow many times what the slowest correct run needs
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int RANDOM_BEATS    = 275;  // per random-traffic phase, four phases

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    // one predicted result beat
    typedef struct {
        word_t    front;
        word_t    back;
        word_t    maxv;
        logic [4:0] count;
        logic     is_empty;
        status_t  status;
    } queue_report_t;

    // ------------------------------------------------------------------------
    // DUT signals; inputs start at known values
    // ------------------------------------------------------------------------
    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    logic               start   = 1'b0;
    logic               command = CMD_PUSH;
    logic signed [31:0] value   = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] max_value;
    logic [4:0]         count;
    logic               is_empty;
    logic [1:0]         status;

    always #(CLK_PERIOD / 2) clk = ~clk;

    fifo_with_running_maximum #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .value       (value),
        .done        (done),
        .front_value (front_value),
        .back_value  (back_value),
        .max_value   (max_value),
        .count       (count),
        .is_empty    (is_empty),
        .status      (status)
    );

    // ------------------------------------------------------------------------
    // Shadow queue and the reports still owed by the DUT
    // ------------------------------------------------------------------------
    word_t         held_words[$];
    queue_report_t pending_reports[$];

    int mismatches     = 0;
    int reports_seen   = 0;
    int push_beats     = 0;
    int pop_beats      = 0;
    int full_rejects   = 0;
    int empty_rejects  = 0;
    int peak_fill      = 0;

    // Applies one beat to the shadow queue and returns the report it owes.
    // Maximum is always rescanned over what is held, so popped values drop out.
    function automatic queue_report_t apply_beat(command_t cmd, word_t val);
        queue_report_t r;
        r.status = STATUS_OK;
        if (cmd == CMD_PUSH)
        begin
            push_beats++;
            if (held_words.size() >= DEPTH)
            begin
                r.status = STATUS_PUSH_FULL;
                full_rejects++;
            end
            else
                held_words.push_back(val);
        end
        else
        begin
            pop_beats++;
            if (held_words.size() == 0)
            begin
                r.status = STATUS_POP_EMPTY;
                empty_rejects++;
            end
            else
                void'(held_words.pop_front());
        end
        if (held_words.size() > peak_fill)
            peak_fill = held_words.size();

        r.count    = 5'(held_words.size());
        r.is_empty = (held_words.size() == 0);
        r.front    = '0;
        r.back     = '0;
        r.maxv     = '0;
        if (held_words.size() > 0)
        begin
            r.front = held_words[0];
            r.back  = held_words[$];
            r.maxv  = held_words[0];
            foreach (held_words[i])
                if (held_words[i] > r.maxv)
                    r.maxv = held_words[i];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on result %0d, %s: got 0x%08h, expected 0x%08h",
                 $time, reports_seen, field, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Result checker: done is sampled at the edge that ends its cycle
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        queue_report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                // result beat with nothing outstanding
                report_mismatch("unexpected done", 32'(done), 32'(1'b0));
            end
            else
            begin
                want = pending_reports.pop_front();
                if (front_value !== want.front)
                    report_mismatch("front_value", front_value, want.front);
                if (back_value !== want.back)
                    report_mismatch("back_value", back_value, want.back);
                if (max_value !== want.maxv)
                    report_mismatch("max_value", max_value, want.maxv);
                if (count !== want.count)
                    report_mismatch("count", 32'(count), 32'(want.count));
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
            end
            reports_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offers one beat and returns right after the edge that takes it.
    // start is left high so back-to-back beats need no extra edge.
    task automatic send_beat(command_t cmd, word_t val);
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_reports.push_back(apply_beat(cmd, val));
    endtask

    // One cycle with start low; the payload carries noise the DUT must ignore.
    task automatic idle_cycle();
        start   <= 1'b0;
        command <= 1'($urandom_range(1));
        value   <= $urandom;
        @(posedge clk);
    endtask

    // Holds off until every owed report has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, zero, minus one, small values for ties, or a full random word.
    function automatic word_t pick_word();
        case ($urandom_range(7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return word_t'($urandom_range(16)) - 8;
            3:       return $urandom_range(1) ? word_t'(0) : word_t'(-1);
            default: return word_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Pop straight out of reset: status flags it and all value fields read zero.
    task automatic test_pop_on_empty();
        send_beat(CMD_POP, WORD_MAX);
    endtask

    // Fill to the brim with extremes, a duplicated maximum and small values.
    task automatic test_fill_to_full();
        send_beat(CMD_PUSH, WORD_MAX);
        send_beat(CMD_PUSH, WORD_MIN);
        send_beat(CMD_PUSH, 0);
        send_beat(CMD_PUSH, -1);
        send_beat(CMD_PUSH, 1);
        send_beat(CMD_PUSH, WORD_MAX);
        for (int i = 0; i < DEPTH - 6; i++)
            send_beat(CMD_PUSH, word_t'(i) - 5);
    endtask

    // Push into a full queue is dropped with a status code.
    task automatic test_push_on_full();
        send_beat(CMD_PUSH, 32'sh1234_5678);
    endtask

    // Popping the front maximum must not leave a stale maximum behind:
    // first pop hits the tied copy, later pops retire the second one.
    task automatic test_stale_maximum();
        repeat (6)
            send_beat(CMD_POP, WORD_MIN);
    endtask

    // Random traffic with a drifting push bias so the queue swings between
    // empty and full and the head wraps many times.
    task automatic test_random_traffic(int beats, int idle_pct);
        int       push_bias;
        command_t cmd;
        push_bias = 50;
        for (int n = 0; n < beats; n++)
        begin
            if (n % 24 == 0)
                case ($urandom_range(2))
                    0:       push_bias = 15;
                    1:       push_bias = 50;
                    default: push_bias = 85;
                endcase
            while ($urandom_range(99) < idle_pct)
                idle_cycle();
            cmd = ($urandom_range(99) < push_bias) ? CMD_PUSH : CMD_POP;
            send_beat(cmd, pick_word());
        end
    endtask

    // Sender stops until the pipeline is empty, then resumes mid-state.
    task automatic test_pause_until_drained();
        send_beat(CMD_PUSH, pick_word());
        send_beat(CMD_PUSH, pick_word());
        wait_for_drain();
        send_beat(CMD_POP, pick_word());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pop_on_empty();
        test_fill_to_full();
        test_push_on_full();
        test_stale_maximum();

        test_random_traffic(RANDOM_BEATS, 0);    // back to back
        test_pause_until_drained();
        test_random_traffic(RANDOM_BEATS, 80);   // sender mostly idle
        test_random_traffic(RANDOM_BEATS, 16);   // light gaps
        test_pause_until_drained();
        test_random_traffic(RANDOM_BEATS, 0);

        // let the last reports out, then keep clocking to catch any stray result
        wait_for_drain();
        repeat (LATENCY + 4)
            @(posedge clk);

        $display("covered %0d beats: %0d push (%0d on full), %0d pop (%0d on empty)",
                 push_beats + pop_beats, push_beats, full_rejects, pop_beats, empty_rejects);
        $display("peak fill %0d, checked %0d result beats, %0d mismatches",
                 peak_fill, reports_seen, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: a hung handshake or missing result ends the run here.
    initial
    begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("watchdog expired with %0d results outstanding", pending_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
